// ----- hdl/bsll_pkg.sv -----
// Shared types and codes for the bounded singly linked list.
`timescale 1ns / 1ps
`default_nettype none

package bsll_pkg;

    localparam logic [2:0] OP_ADD_BACK     = 3'd0;
    localparam logic [2:0] OP_ADD_FRONT    = 3'd1;
    localparam logic [2:0] OP_REMOVE_FRONT = 3'd2;
    localparam logic [2:0] OP_INSERT_AFTER = 3'd3;
    localparam logic [2:0] OP_DUMP         = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [2:0]         op;
        logic [3:0]         position;
        logic signed [31:0] value;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data;
        logic [4:0]         count;
        logic               last;
    } res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_REM_RD,
        S_WALK,
        S_INS_NODE,
        S_INS_LINK,
        S_DUMP,
        S_EMIT
    } state_t;

endpackage

`default_nettype wire

// ----- hdl/bsll_free_slot.sv -----
// Lowest-numbered free slot finder over the allocation map.
`timescale 1ns / 1ps
`default_nettype none

module bsll_free_slot #(
    parameter int CAPACITY = 16
) (
    input  wire logic [CAPACITY-1:0]         in_use,
    output logic      [$clog2(CAPACITY)-1:0] slot
);

    localparam int SW = $clog2(CAPACITY);

    always_comb
    begin
        slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (!in_use[i])
            begin
                slot = SW'(i);
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/bounded_singly_linked_list.sv -----
// Top level of the bounded singly linked list over a fixed node pool.
//
// One request enters on cmd (valid/ready) and gives one or more results on
// res (valid/ready). Every result carries the element count after the
// operation; last marks the final result of a request. A small sequencer
// drives one read port and one write port of the value and link memories.
// The sequencer steps through S_DECODE and S_EMIT for an add back or
// front, an error or an unused code; a remove front adds S_REM_RD, and an
// insert after adds S_WALK, one link per index step, then S_INS_NODE and
// S_INS_LINK. A dump shows its elements in order, one element per cycle
// while the receiver does not stall, since each step follows one link read.
// cmd_ready is high only while the sequencer is idle, which starts at the
// edge that registers the final result of the previous request, so requests
// are never overlapped; a waiting result in the output register does not
// block the next request.
// When the receiver stalls, the sequencer holds before loading a new
// result, so nothing is dropped. Reset empties the list and the output
// register; node memories are not cleared, as only allocated slots are read.
`timescale 1ns / 1ps
`default_nettype none

module bounded_singly_linked_list
    import bsll_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    output logic      cmd_ready,
    input  wire cmd_t cmd,
    output logic      res_valid,
    input  wire logic res_ready,
    output res_t      res
);

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 4) ? CW : 4;

    state_t state_reg, state_next;

    logic [CAPACITY-1:0] in_use_reg, in_use_next;
    logic [SW-1:0]       head_reg, head_next;
    logic [SW-1:0]       tail_reg, tail_next;
    logic [CW-1:0]       count_reg, count_next;

    logic [2:0]            op_reg;
    logic [3:0]            pos_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    logic [SW-1:0]         cur_reg, cur_next;
    logic [3:0]            step_reg, step_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [SW-1:0]         slot_reg, slot_next;
    logic [1:0]            rstat_reg, rstat_next;
    logic [31:0]           rdata_reg, rdata_next;

    logic out_valid_reg;
    res_t out_reg, out_next;
    logic out_load;
    logic out_free;

    logic [DATA_WIDTH-1:0] val_mem [CAPACITY];
    logic [SW-1:0]         link_mem [CAPACITY];
    logic [DATA_WIDTH-1:0] rd_val_reg;
    logic [SW-1:0]         rd_link_reg;
    logic                  rd_en;
    logic [SW-1:0]         rd_addr;
    logic                  val_we;
    logic [SW-1:0]         val_waddr;
    logic                  link_we;
    logic [SW-1:0]         link_waddr;
    logic [SW-1:0]         link_wdata;

    logic [SW-1:0]            free_slot;
    logic [DATA_WIDTH+31:0]   store_wide;
    logic [DATA_WIDTH-1:0]    store_val;
    logic [DATA_WIDTH+31:0]   shown_wide;
    logic [31:0]              shown_val;
    logic                     is_full;
    logic                     is_empty;
    logic                     is_range;
    logic                     dump_last;

    bsll_free_slot #(
        .CAPACITY (CAPACITY)
    ) u_free_slot (
        .in_use (in_use_reg),
        .slot   (free_slot)
    );

    assign store_wide = {{DATA_WIDTH{cmd.value[31]}}, cmd.value};
    assign store_val  = store_wide[DATA_WIDTH-1:0];
    assign shown_wide = {{32{rd_val_reg[DATA_WIDTH-1]}}, rd_val_reg};
    assign shown_val  = shown_wide[31:0];

    assign is_full   = (count_reg == CW'(CAPACITY));
    assign is_empty  = (count_reg == '0);
    assign is_range  = (PW'(pos_reg) >= PW'(count_reg));
    assign dump_last = ((idx_reg + CW'(1)) == count_reg);

    assign out_free  = !out_valid_reg || res_ready;
    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (op_reg)
                    OP_REMOVE_FRONT: state_next = is_empty ? S_EMIT : S_REM_RD;
                    OP_INSERT_AFTER: state_next = (is_range || is_full) ? S_EMIT : S_WALK;
                    OP_DUMP:         state_next = is_empty ? S_EMIT : S_DUMP;
                    default:         state_next = S_EMIT;
                endcase
            end
            S_REM_RD:   state_next = S_EMIT;
            S_WALK:
            begin
                if (step_reg == pos_reg)
                begin
                    state_next = S_INS_NODE;
                end
            end
            S_INS_NODE: state_next = S_INS_LINK;
            S_INS_LINK: state_next = S_EMIT;
            S_DUMP:
            begin
                if (out_free && dump_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_use_next = in_use_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        cur_next    = cur_reg;
        step_next   = step_reg;
        idx_next    = idx_reg;
        slot_next   = slot_reg;
        rstat_next  = rstat_reg;
        rdata_next  = rdata_reg;
        rd_en       = 1'b0;
        rd_addr     = head_reg;
        val_we      = 1'b0;
        val_waddr   = free_slot;
        link_we     = 1'b0;
        link_waddr  = free_slot;
        link_wdata  = free_slot;
        out_load    = 1'b0;
        out_next    = out_reg;

        unique case (state_reg)
            S_IDLE:
            begin
            end
            S_DECODE:
            begin
                rstat_next = ST_OK;
                rdata_next = '0;
                case (op_reg)
                    OP_ADD_BACK:
                    begin
                        if (is_full)
                        begin
                            rstat_next = ST_FULL;
                        end
                        else
                        begin
                            val_we      = 1'b1;
                            link_we     = !is_empty;
                            link_waddr  = tail_reg;
                            link_wdata  = free_slot;
                            head_next   = is_empty ? free_slot : head_reg;
                            tail_next   = free_slot;
                            in_use_next = in_use_reg | (CAPACITY'(1) << free_slot);
                            count_next  = count_reg + CW'(1);
                        end
                    end
                    OP_ADD_FRONT:
                    begin
                        if (is_full)
                        begin
                            rstat_next = ST_FULL;
                        end
                        else
                        begin
                            val_we      = 1'b1;
                            link_we     = 1'b1;
                            link_waddr  = free_slot;
                            link_wdata  = head_reg;
                            head_next   = free_slot;
                            tail_next   = is_empty ? free_slot : tail_reg;
                            in_use_next = in_use_reg | (CAPACITY'(1) << free_slot);
                            count_next  = count_reg + CW'(1);
                        end
                    end
                    OP_REMOVE_FRONT:
                    begin
                        if (is_empty)
                        begin
                            rstat_next = ST_EMPTY;
                        end
                        else
                        begin
                            rd_en = 1'b1;
                        end
                    end
                    OP_INSERT_AFTER:
                    begin
                        if (is_range)
                        begin
                            rstat_next = ST_RANGE;
                        end
                        else if (is_full)
                        begin
                            rstat_next = ST_FULL;
                        end
                        else
                        begin
                            rd_en     = 1'b1;
                            cur_next  = head_reg;
                            step_next = '0;
                        end
                    end
                    OP_DUMP:
                    begin
                        if (is_empty)
                        begin
                            rstat_next = ST_EMPTY;
                        end
                        else
                        begin
                            rd_en    = 1'b1;
                            idx_next = '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_REM_RD:
            begin
                rstat_next  = ST_OK;
                rdata_next  = shown_val;
                head_next   = rd_link_reg;
                in_use_next = in_use_reg & ~(CAPACITY'(1) << head_reg);
                count_next  = count_reg - CW'(1);
            end
            S_WALK:
            begin
                if (step_reg != pos_reg)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = rd_link_reg;
                    cur_next  = rd_link_reg;
                    step_next = step_reg + 4'd1;
                end
            end
            S_INS_NODE:
            begin
                val_we      = 1'b1;
                link_we     = 1'b1;
                link_waddr  = free_slot;
                link_wdata  = rd_link_reg;
                slot_next   = free_slot;
                tail_next   = (cur_reg == tail_reg) ? free_slot : tail_reg;
                in_use_next = in_use_reg | (CAPACITY'(1) << free_slot);
                count_next  = count_reg + CW'(1);
            end
            S_INS_LINK:
            begin
                link_we    = 1'b1;
                link_waddr = cur_reg;
                link_wdata = slot_reg;
                rstat_next = ST_OK;
                rdata_next = '0;
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_next.status = ST_OK;
                    out_next.data   = shown_val;
                    out_next.count  = 5'(count_reg);
                    out_next.last   = dump_last;
                    if (!dump_last)
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = rd_link_reg;
                        idx_next = idx_reg + CW'(1);
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_next.status = rstat_reg;
                    out_next.data   = rdata_reg;
                    out_next.count  = 5'(count_reg);
                    out_next.last   = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_use_reg    <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            in_use_reg <= in_use_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            op_reg  <= cmd.op;
            pos_reg <= cmd.position;
            val_reg <= store_val;
        end
        cur_reg   <= cur_next;
        step_reg  <= step_next;
        idx_reg   <= idx_next;
        slot_reg  <= slot_next;
        rstat_reg <= rstat_next;
        rdata_reg <= rdata_next;
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_val_reg  <= val_mem[rd_addr];
            rd_link_reg <= link_mem[rd_addr];
        end
        if (val_we)
        begin
            val_mem[val_waddr] <= val_reg;
        end
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("element count exceeds capacity");

    a_map_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(in_use_reg) == count_reg)
        else $error("allocation map disagrees with element count");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("request accepted while a previous one is in progress");

    a_partial_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.last |-> res.status == ST_OK)
        else $error("non-final result carries an error status");

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for the bounded singly linked list with its own list scoreboard.
`timescale 1ns / 1ps

module testbench
    import bsll_pkg::*;
();

    localparam int CAP          = 16;
    localparam int ITEMS        = 470;
    localparam int HOLD_AT      = 120;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_LIMIT  = 50000;
    localparam int TAIL_CYCLES  = 60;
    localparam logic [2:0] OP_LAST_CODE = 3'd7;

    typedef enum int {GROW, SHRINK, MIXED} traffic_mode_t;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;
    logic res_valid;
    logic res_ready;
    res_t res;

    int n_sent;
    int n_results;
    bit tx_quiet;
    bit rx_quiet;

    class list_scoreboard;
        logic signed [31:0] node_val [CAP];
        logic [3:0]         node_nxt [CAP];
        logic [CAP-1:0]     slot_busy;
        logic [3:0]         head;
        logic [3:0]         tail;
        logic [4:0]         count;
        res_t               replies_due [$];
        int                 mismatches;

        function new();
            foreach (node_val[i])
            begin
                node_val[i] = '0;
                node_nxt[i] = '0;
            end
            slot_busy  = '0;
            head       = '0;
            tail       = '0;
            count      = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        function void push(logic [1:0] st, logic signed [31:0] d, logic l);
            res_t r;
            r.status = st;
            r.data   = d;
            r.count  = count;
            r.last   = l;
            replies_due.push_back(r);
        endfunction

        function logic [3:0] grab_slot(logic signed [31:0] v);
            int i;
            for (i = 0; i < CAP; i++)
            begin
                if (!slot_busy[i])
                    break;
            end
            slot_busy[i] = 1'b1;
            node_val[i]  = v;
            return i[3:0];
        endfunction

        function void apply_request(cmd_t c);
            logic [3:0]         s;
            logic [3:0]         cur;
            logic signed [31:0] d;
            int                 i;
            case (c.op)
                OP_ADD_BACK, OP_ADD_FRONT:
                begin
                    if (count == CAP)
                        push(ST_FULL, '0, 1'b1);
                    else
                    begin
                        s = grab_slot(c.value);
                        if (count == 0)
                        begin
                            head = s;
                            tail = s;
                        end
                        else if (c.op == OP_ADD_BACK)
                        begin
                            node_nxt[tail] = s;
                            tail = s;
                        end
                        else
                        begin
                            node_nxt[s] = head;
                            head = s;
                        end
                        count++;
                        push(ST_OK, '0, 1'b1);
                    end
                end
                OP_REMOVE_FRONT:
                begin
                    if (count == 0)
                        push(ST_EMPTY, '0, 1'b1);
                    else
                    begin
                        d = node_val[head];
                        slot_busy[head] = 1'b0;
                        head = node_nxt[head];
                        count--;
                        push(ST_OK, d, 1'b1);
                    end
                end
                OP_INSERT_AFTER:
                begin
                    if (c.position >= count)
                        push(ST_RANGE, '0, 1'b1);
                    else if (count == CAP)
                        push(ST_FULL, '0, 1'b1);
                    else
                    begin
                        cur = head;
                        for (i = 0; i < c.position; i++)
                            cur = node_nxt[cur];
                        s = grab_slot(c.value);
                        node_nxt[s]   = node_nxt[cur];
                        node_nxt[cur] = s;
                        if (cur == tail)
                            tail = s;
                        count++;
                        push(ST_OK, '0, 1'b1);
                    end
                end
                OP_DUMP:
                begin
                    if (count == 0)
                        push(ST_EMPTY, '0, 1'b1);
                    else
                    begin
                        cur = head;
                        for (i = 0; i < count; i++)
                        begin
                            push(ST_OK, node_val[cur], i == count - 1);
                            cur = node_nxt[cur];
                        end
                    end
                end
                default:
                    push(ST_OK, '0, 1'b1);
            endcase
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (replies_due.size() == 0)
            begin
                $error("unexpected result: status %0d data %0d count %0d last %0d",
                       got.status, got.data, got.count, got.last);
                mismatches++;
                return;
            end
            want = replies_due.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.data !== want.data)
            begin
                $error("data: expected %0d, got %0d", want.data, got.data);
                mismatches++;
            end
            if (got.count !== want.count)
            begin
                $error("count: expected %0d, got %0d", want.count, got.count);
                mismatches++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                mismatches++;
            end
        endfunction
    endclass

    list_scoreboard shadow_list;

    bounded_singly_linked_list DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [31:0] pick_value();
        if ($urandom_range(0, 9) != 0)
            return $urandom;
        case ($urandom_range(0, 3))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    function automatic logic [2:0] pick_op(traffic_mode_t mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            GROW:
            begin
                if (r < 35) return OP_ADD_BACK;
                if (r < 60) return OP_ADD_FRONT;
                if (r < 85) return OP_INSERT_AFTER;
                if (r < 90) return OP_REMOVE_FRONT;
                if (r < 95) return OP_DUMP;
            end
            SHRINK:
            begin
                if (r < 10) return OP_ADD_BACK;
                if (r < 15) return OP_ADD_FRONT;
                if (r < 25) return OP_INSERT_AFTER;
                if (r < 75) return OP_REMOVE_FRONT;
                if (r < 92) return OP_DUMP;
            end
            default:
            begin
                if (r < 20) return OP_ADD_BACK;
                if (r < 35) return OP_ADD_FRONT;
                if (r < 55) return OP_INSERT_AFTER;
                if (r < 80) return OP_REMOVE_FRONT;
                if (r < 95) return OP_DUMP;
            end
        endcase
        return 3'($urandom_range(OP_DUMP + 1, OP_LAST_CODE));
    endfunction

    task automatic send_request(input logic [2:0] op, input logic [3:0] pos,
                                input logic signed [31:0] val);
        cmd_t c;
        int   gap;
        c.op       = op;
        c.position = pos;
        c.value    = val;
        gap = tx_quiet ? 0 : $urandom_range(0, 19);
        if ($urandom_range(0, 24) == 0)
            tx_quiet = !tx_quiet;
        if (gap > 0)
        begin
            cmd_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd       = c;
        cmd_valid = 1'b1;
        do
            @(posedge clk);
        while (!cmd_ready);
        shadow_list.apply_request(c);
        n_sent++;
        @(negedge clk);
    endtask

    initial
    begin
        int stall;
        res_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (n_results == HOLD_AT)
                stall = HOLD_CYCLES;
            else
                stall = rx_quiet ? 0 : $urandom_range(0, 19);
            if ($urandom_range(0, 24) == 0)
                rx_quiet = !rx_quiet;
            if (stall > 0)
            begin
                res_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ready = 1'b1;
            do
                @(posedge clk);
            while (!res_valid);
            shadow_list.check_result(res);
            n_results++;
            @(negedge clk);
        end
    end

    initial
    begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        traffic_mode_t mode;
        int            seg_left;
        int            op_code;
        int            wait_cycles;
        logic [2:0]    op;
        logic [3:0]    pos;
        shadow_list = new();
        n_sent    = 0;
        n_results = 0;
        tx_quiet  = 1'b0;
        rx_quiet  = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        rst_n     = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_request(OP_DUMP, 4'd0, '0);
        send_request(OP_REMOVE_FRONT, 4'd0, '0);
        send_request(OP_INSERT_AFTER, 4'd0, 32'd7);
        for (op_code = OP_DUMP + 1; op_code <= OP_LAST_CODE; op_code++)
            send_request(3'(op_code), 4'hF, '1);
        send_request(OP_ADD_BACK, 4'd0, 32'h7FFF_FFFF);
        send_request(OP_ADD_FRONT, 4'd0, 32'h8000_0000);
        send_request(OP_INSERT_AFTER, 4'd1, '0);
        send_request(OP_INSERT_AFTER, 4'd0, '1);
        send_request(OP_DUMP, 4'd0, '0);
        send_request(OP_INSERT_AFTER, 4'hF, 32'd1);
        send_request(OP_REMOVE_FRONT, 4'd0, '0);
        send_request(OP_INSERT_AFTER, 4'd2, 32'h5A5A_5A5A);
        send_request(OP_DUMP, 4'd0, '0);

        mode     = GROW;
        seg_left = $urandom_range(10, 40);
        while (n_sent < ITEMS)
        begin
            if (seg_left == 0)
            begin
                mode     = traffic_mode_t'($urandom_range(GROW, MIXED));
                seg_left = $urandom_range(10, 40);
            end
            seg_left--;
            op = pick_op(mode);
            if (op == OP_INSERT_AFTER && shadow_list.count > 0 && $urandom_range(0, 9) < 8)
                pos = 4'($urandom_range(0, shadow_list.count - 1));
            else
                pos = 4'($urandom_range(0, 15));
            send_request(op, pos, pick_value());
        end
        cmd_valid = 1'b0;

        wait_cycles = 0;
        while (shadow_list.pending() != 0 && wait_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (shadow_list.pending() != 0)
        begin
            $error("%0d expected results never arrived", shadow_list.pending());
            shadow_list.mismatches++;
        end
        if (shadow_list.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/bsll_pkg.sv
hdl/bsll_free_slot.sv
hdl/bounded_singly_linked_list.sv
verif/testbench.sv
